[src/multi_memory_programming_port_top_assert.svh]
// assertion macros for the multi-memory programming port
`ifndef MULTI_MEMORY_PROGRAMMING_PORT_TOP_ASSERT_SVH
`define MULTI_MEMORY_PROGRAMMING_PORT_TOP_ASSERT_SVH
`ifndef SYNTH
// consequent must hold in the same cycle as the antecedent
`define MMPP_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define MMPP_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("next-cycle check failed");
`else
`define MMPP_ASSERT_SAME(lbl, ant, con)
`define MMPP_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

[src/mmpp_pkg.sv]
// shared types and constants for the multi-memory programming port
package mmpp_pkg;

  localparam int WORD_WIDTH = 40;
  localparam int DATA_W     = 40;
  localparam int ADDR_W     = 16;
  localparam int TARGET_W   = 3;
  localparam int MODE_W     = 2;
  localparam int NUM_MEM    = 5;

  // depths are powers of two, so address folding is a bit select; pointers wrap after the last entry
  localparam int AM_DEPTH  = 1024;
  localparam int MM_DEPTH  = 65536;
  localparam int PAT_DEPTH = 64;
  localparam int TAT_DEPTH = 1024;

  localparam int AM_AW  = $clog2(AM_DEPTH);
  localparam int MM_AW  = $clog2(MM_DEPTH);
  localparam int PAT_AW = $clog2(PAT_DEPTH);
  localparam int TAT_AW = $clog2(TAT_DEPTH);

  localparam logic [AM_AW-1:0]  AM_LAST  = AM_AW'(AM_DEPTH - 1);
  localparam logic [MM_AW-1:0]  MM_LAST  = MM_AW'(MM_DEPTH - 1);
  localparam logic [TAT_AW-1:0] TAT_LAST = TAT_AW'(TAT_DEPTH - 1);

  localparam int IN_TDATA_W  = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = TARGET_W + MODE_W;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = TARGET_W + 1;

  // target codes
  localparam logic [TARGET_W-1:0] T_AM   = 3'd0;
  localparam logic [TARGET_W-1:0] T_MM   = 3'd1;
  localparam logic [TARGET_W-1:0] T_PAT  = 3'd2;
  localparam logic [TARGET_W-1:0] T_TAT0 = 3'd3;
  localparam logic [TARGET_W-1:0] T_TAT1 = 3'd4;

  // AM modes
  localparam logic [MODE_W-1:0] AM_SET = 2'd0;
  localparam logic [MODE_W-1:0] AM_RW  = 2'd1;
  localparam logic [MODE_W-1:0] AM_INC = 2'd2;
  // MM and TAT modes
  localparam logic [MODE_W-1:0] PT_SET       = 2'd0;
  localparam logic [MODE_W-1:0] PT_WRITE_INC = 2'd1;
  localparam logic [MODE_W-1:0] PT_READ_INC  = 2'd2;
  // PAT modes
  localparam logic [MODE_W-1:0] PAT_READ  = 2'd0;
  localparam logic [MODE_W-1:0] PAT_WRITE = 2'd1;

  // result status
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [NUM_MEM-1:0] en;
    logic [NUM_MEM-1:0] we;
    logic [AM_AW-1:0]   am_addr;
    logic [MM_AW-1:0]   mm_addr;
    logic [PAT_AW-1:0]  pat_addr;
    logic [TAT_AW-1:0]  tat0_addr;
    logic [TAT_AW-1:0]  tat1_addr;
    word_t              wdata;
  } mem_cmd_t;

  typedef struct packed {
    logic                pend;     // read issued, data lands next cycle
    logic [TARGET_W-1:0] src;      // memory of the pending read
    logic                err;      // invalid word accepted this cycle
    logic                is_read;  // offered word is a valid read
  } seq_stat_t;

endpackage

[src/mmpp_ram.sv]
// generic single-port synchronous ram, read-before-write
module mmpp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

[src/mmpp_seq.sv]
// request decode, address pointers and memory command issue
module mmpp_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mmpp_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [mmpp_pkg::IN_TUSER_W-1:0]    s_tuser,
  input  logic                               out_free,
  output mmpp_pkg::mem_cmd_t                 cmd,
  output mmpp_pkg::seq_stat_t                stat
);

  logic [mmpp_pkg::TARGET_W-1:0] target;
  logic [mmpp_pkg::MODE_W-1:0]   mode;
  logic [mmpp_pkg::ADDR_W-1:0]   address;
  logic [mmpp_pkg::DATA_W-1:0]   data;

  logic [mmpp_pkg::AM_AW-1:0]  am_ptr;
  logic [mmpp_pkg::MM_AW-1:0]  mm_ptr;
  logic [mmpp_pkg::TAT_AW-1:0] tat0_ptr;
  logic [mmpp_pkg::TAT_AW-1:0] tat1_ptr;

  logic                          pend;
  logic [mmpp_pkg::TARGET_W-1:0] pend_src;

  logic accept;
  logic is_ptr_mem;
  logic valid_req;
  logic is_read;

  assign target  = s_tuser[mmpp_pkg::TARGET_W-1:0];
  assign mode    = s_tuser[mmpp_pkg::IN_TUSER_W-1:mmpp_pkg::TARGET_W];
  assign address = s_tdata[mmpp_pkg::ADDR_W-1:0];
  assign data    = s_tdata[mmpp_pkg::ADDR_W+mmpp_pkg::DATA_W-1:mmpp_pkg::ADDR_W];

  // one word in flight at most; a read needs the result register free
  assign s_tready = !rst && !pend && out_free;
  assign accept   = s_tvalid && s_tready;

  assign is_ptr_mem = (target == mmpp_pkg::T_MM) || (target == mmpp_pkg::T_TAT0) ||
                      (target == mmpp_pkg::T_TAT1);

  always_comb begin
    valid_req = 1'b0;
    is_read   = 1'b0;
    case (target)
      mmpp_pkg::T_AM: begin
        valid_req = mode inside {mmpp_pkg::AM_SET, mmpp_pkg::AM_RW, mmpp_pkg::AM_INC};
        is_read   = (mode == mmpp_pkg::AM_RW);
      end
      mmpp_pkg::T_MM, mmpp_pkg::T_TAT0, mmpp_pkg::T_TAT1: begin
        valid_req = mode inside {mmpp_pkg::PT_SET, mmpp_pkg::PT_WRITE_INC,
                                 mmpp_pkg::PT_READ_INC};
        is_read   = (mode == mmpp_pkg::PT_READ_INC);
      end
      mmpp_pkg::T_PAT: begin
        valid_req = (mode == mmpp_pkg::PAT_READ) || (mode == mmpp_pkg::PAT_WRITE);
        is_read   = (mode == mmpp_pkg::PAT_READ);
      end
      default: begin
        valid_req = 1'b0;
        is_read   = 1'b0;
      end
    endcase
  end

  // memory commands go out in the accept cycle
  always_comb begin
    cmd           = '0;
    cmd.am_addr   = am_ptr;
    cmd.mm_addr   = mm_ptr;
    cmd.pat_addr  = address[mmpp_pkg::PAT_AW-1:0];
    cmd.tat0_addr = tat0_ptr;
    cmd.tat1_addr = tat1_ptr;
    cmd.wdata     = mmpp_pkg::word_t'(data);
    if (accept && valid_req) begin
      case (target)
        mmpp_pkg::T_AM: begin
          cmd.en[mmpp_pkg::T_AM] = (mode == mmpp_pkg::AM_RW);
          cmd.we[mmpp_pkg::T_AM] = (mode == mmpp_pkg::AM_RW);
        end
        mmpp_pkg::T_PAT: begin
          cmd.en[mmpp_pkg::T_PAT] = 1'b1;
          cmd.we[mmpp_pkg::T_PAT] = (mode == mmpp_pkg::PAT_WRITE);
        end
        default: begin
          if (is_ptr_mem) begin
            cmd.en[target] = (mode == mmpp_pkg::PT_WRITE_INC) ||
                             (mode == mmpp_pkg::PT_READ_INC);
            cmd.we[target] = (mode == mmpp_pkg::PT_WRITE_INC);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      am_ptr   <= '0;
      mm_ptr   <= '0;
      tat0_ptr <= '0;
      tat1_ptr <= '0;
      pend     <= 1'b0;
      pend_src <= '0;
    end else begin
      pend <= accept && valid_req && is_read;
      if (accept) begin
        pend_src <= target;
      end
      if (accept && valid_req) begin
        case (target)
          mmpp_pkg::T_AM: begin
            if (mode == mmpp_pkg::AM_SET) begin
              am_ptr <= address[mmpp_pkg::AM_AW-1:0];
            end else if (mode == mmpp_pkg::AM_INC) begin
              am_ptr <= (am_ptr == mmpp_pkg::AM_LAST) ? '0 : am_ptr + 1'b1;
            end
          end
          mmpp_pkg::T_MM: begin
            if (mode == mmpp_pkg::PT_SET) begin
              mm_ptr <= address[mmpp_pkg::MM_AW-1:0];
            end else begin
              mm_ptr <= (mm_ptr == mmpp_pkg::MM_LAST) ? '0 : mm_ptr + 1'b1;
            end
          end
          mmpp_pkg::T_TAT0: begin
            if (mode == mmpp_pkg::PT_SET) begin
              tat0_ptr <= address[mmpp_pkg::TAT_AW-1:0];
            end else begin
              tat0_ptr <= (tat0_ptr == mmpp_pkg::TAT_LAST) ? '0 : tat0_ptr + 1'b1;
            end
          end
          mmpp_pkg::T_TAT1: begin
            if (mode == mmpp_pkg::PT_SET) begin
              tat1_ptr <= address[mmpp_pkg::TAT_AW-1:0];
            end else begin
              tat1_ptr <= (tat1_ptr == mmpp_pkg::TAT_LAST) ? '0 : tat1_ptr + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign stat.pend    = pend;
  assign stat.src     = pend_src;
  assign stat.err     = accept && !valid_req;
  assign stat.is_read = is_read && valid_req;

endmodule

[src/mmpp_out.sv]
// result register: picks the returning read word or an error word
module mmpp_out (
  input  logic                              clk,
  input  logic                              rst,
  input  mmpp_pkg::seq_stat_t               stat,
  input  mmpp_pkg::word_t                   rdata [mmpp_pkg::NUM_MEM],
  output logic                              out_free,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mmpp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [mmpp_pkg::OUT_TUSER_W-1:0]  m_tuser
);

  mmpp_pkg::word_t sel_word;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (stat.src)
      mmpp_pkg::T_AM:   sel_word = rdata[0];
      mmpp_pkg::T_MM:   sel_word = rdata[1];
      mmpp_pkg::T_PAT:  sel_word = rdata[2];
      mmpp_pkg::T_TAT0: sel_word = rdata[3];
      mmpp_pkg::T_TAT1: sel_word = rdata[4];
      default:          sel_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stat.pend || stat.err) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.pend) begin
      m_tdata <= mmpp_pkg::OUT_TDATA_W'(sel_word[mmpp_pkg::DATA_W-1:0]);
      m_tuser <= {mmpp_pkg::ST_OK, stat.src};
    end else if (stat.err) begin
      m_tdata <= '0;
      m_tuser <= {mmpp_pkg::ST_ERR, mmpp_pkg::T_AM};
    end
  end

endmodule

[src/multi_memory_programming_port_top.sv]
// top level of the multi-memory programming port
//
//  channel  dir  tdata                                 tuser
//  s_*      in   [15:0] address, [55:16] data          [2:0] target, [4:3] mode
//  m_*      out  [39:0] read_data                      [2:0] source, [3] status
//
// set, write and increment words give no result
// a read word goes through one ram access, then the result register
// invalid words give an error result in the next cycle without touching a ram
// rst is synchronous and clears the pointers and valid flags; ram contents are
// undefined until written; s_tready stays low during reset
// every word waits for the result register to be free, so a stalled m side
// stalls the s side once a result is waiting
`include "multi_memory_programming_port_top_assert.svh"

module multi_memory_programming_port_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mmpp_pkg::IN_TDATA_W-1:0]   s_tdata,   // address, data
  input  logic [mmpp_pkg::IN_TUSER_W-1:0]   s_tuser,   // target, mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mmpp_pkg::OUT_TDATA_W-1:0]  m_tdata,   // read_data
  output logic [mmpp_pkg::OUT_TUSER_W-1:0]  m_tuser    // source, status
);

  mmpp_pkg::mem_cmd_t  cmd;
  mmpp_pkg::seq_stat_t stat;
  mmpp_pkg::word_t     rdata [mmpp_pkg::NUM_MEM];
  logic                out_free;

  // decode, pointers, ram command issue
  mmpp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .out_free (out_free),
    .cmd      (cmd),
    .stat     (stat)
  );

  // one ram per table; am read-write relies on read-before-write
  mmpp_ram #(.DEPTH(mmpp_pkg::AM_DEPTH), .WIDTH(mmpp_pkg::WORD_WIDTH)) u_am_ram (
    .clk   (clk),
    .en    (cmd.en[0]),
    .we    (cmd.we[0]),
    .addr  (cmd.am_addr),
    .wdata (cmd.wdata),
    .rdata (rdata[0])
  );

  mmpp_ram #(.DEPTH(mmpp_pkg::MM_DEPTH), .WIDTH(mmpp_pkg::WORD_WIDTH)) u_mm_ram (
    .clk   (clk),
    .en    (cmd.en[1]),
    .we    (cmd.we[1]),
    .addr  (cmd.mm_addr),
    .wdata (cmd.wdata),
    .rdata (rdata[1])
  );

  mmpp_ram #(.DEPTH(mmpp_pkg::PAT_DEPTH), .WIDTH(mmpp_pkg::WORD_WIDTH)) u_pat_ram (
    .clk   (clk),
    .en    (cmd.en[2]),
    .we    (cmd.we[2]),
    .addr  (cmd.pat_addr),
    .wdata (cmd.wdata),
    .rdata (rdata[2])
  );

  mmpp_ram #(.DEPTH(mmpp_pkg::TAT_DEPTH), .WIDTH(mmpp_pkg::WORD_WIDTH)) u_tat0_ram (
    .clk   (clk),
    .en    (cmd.en[3]),
    .we    (cmd.we[3]),
    .addr  (cmd.tat0_addr),
    .wdata (cmd.wdata),
    .rdata (rdata[3])
  );

  mmpp_ram #(.DEPTH(mmpp_pkg::TAT_DEPTH), .WIDTH(mmpp_pkg::WORD_WIDTH)) u_tat1_ram (
    .clk   (clk),
    .en    (cmd.en[4]),
    .we    (cmd.we[4]),
    .addr  (cmd.tat1_addr),
    .wdata (cmd.wdata),
    .rdata (rdata[4])
  );

  // result register toward the m side
  mmpp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .rdata    (rdata),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // no new word while a read is in flight
  `MMPP_ASSERT_SAME(a_pend_blocks, stat.pend, !s_tready)
  // read data always lands in the result register the cycle after
  `MMPP_ASSERT_NEXT(a_read_lands, stat.pend, m_tvalid && !m_tuser[3])
  // invalid word becomes an error result with zero data
  `MMPP_ASSERT_NEXT(a_err_result, stat.err, m_tvalid && m_tuser[3] && m_tdata == '0)
  // words that give no result leave no read pending
  `MMPP_ASSERT_NEXT(a_no_spurious, s_tvalid && s_tready && !stat.is_read && !stat.err,
                    !stat.pend)

endmodule
